@@ design/rrts_pkg.sv @@
package rrts_pkg;

  // Pool size; ids are 4 bits wide, so the pool is fixed at 16 slots.
  localparam int TASKS = 16;
  localparam int ID_W  = 4;

  // APB register map: one 32-bit register per word.
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_EPOCH_LENGTH = '0;

  localparam logic [7:0] EPOCH_RESET = 8'd2;

  typedef logic [ID_W-1:0] task_id_t;

  typedef enum logic [1:0] {
    SLOT_UNUSED   = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    FUNC_CREATE   = 2'd0,
    FUNC_SCHEDULE = 2'd1,
    FUNC_RESCHED  = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_CREATED   = 2'd0,
    STATUS_POOL_FULL = 2'd1,
    STATUS_SWITCHED  = 2'd2,
    STATUS_NO_SWITCH = 2'd3
  } status_t;

endpackage

@@ design/round_robin_task_scheduler_top.sv @@
// Round-robin task scheduler: a pool of 16 task slots, a ring run queue of
// task ids (15 usable places) and one time-slice counter per task. Each input
// transfer carries one operation (create, schedule, reschedule if the current
// slice is used up, tick) and yields exactly one result transfer. The block
// takes one operation per clock cycle while results are drained; each passes
// through an input register and then a result register, with all table
// lookups, the lowest-free-slot search and the ring push/pop done between
// them. The result register is refilled as it is drained, so results
// flow back to back while the receiver keeps up; while a result waits, the
// input register takes one more operation and then holds in_ready low.
// The time slice loaded on create and on reload is the epoch_length register
// at APB byte address 0 (reset value 2); write it only while the block is
// idle. Task 0 is the idle task: it is never created and its entry address
// reads as zero.
module round_robin_task_scheduler_top (
  input  logic                         clk,
  input  logic                         rst,
  // operation channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [63:0]                  entry_addr,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [3:0]                   task_id,
  output logic [3:0]                   prev_id,
  output logic [63:0]                  next_entry,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrts_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // Input register
  logic        s1_valid;
  rrts_pkg::func_t s1_func;
  logic [63:0] s1_entry;

  // Scheduler state
  rrts_pkg::slot_state_t slot_state [rrts_pkg::TASKS];
  logic [7:0]            time_left  [rrts_pkg::TASKS];
  logic [63:0]           entry_table[rrts_pkg::TASKS];  // written on create only
  rrts_pkg::task_id_t    ring_slots [rrts_pkg::TASKS];  // written on push only
  rrts_pkg::task_id_t    ring_head;
  rrts_pkg::task_id_t    ring_tail;
  rrts_pkg::task_id_t    current_task;
  logic [7:0]            epoch_length;

  // Handshake: the input register moves on whenever the result register is
  // empty or being drained this cycle.
  logic advance;
  logic take;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign take     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func  <= rrts_pkg::func_t'(func);
      s1_entry <= entry_addr;
    end
  end

  // APB: single register, zero wait states.
  logic cfg_write;
  logic cfg_hit;

  assign pready    = 1'b1;
  assign cfg_hit   = paddr[rrts_pkg::ADDR_W-1:2] == rrts_pkg::REG_EPOCH_LENGTH;
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
  assign prdata    = cfg_hit ? {24'd0, epoch_length} : 32'd0;

  // ---------------------------------------------------------------------
  // Operation decode and combinational work
  // ---------------------------------------------------------------------
  rrts_pkg::task_id_t cur_id;
  logic [7:0]         cur_time;
  logic               cur_due;
  logic               free_found;
  rrts_pkg::task_id_t free_id;
  logic               ring_full;
  logic               ring_empty;
  logic               do_create;
  logic               do_sched;
  logic               do_tick;
  logic               prev_active;
  logic               push_en;
  rrts_pkg::task_id_t push_id;
  logic               pop_en;
  rrts_pkg::task_id_t pop_id;
  rrts_pkg::task_id_t next_id;
  rrts_pkg::task_id_t lookup_id;
  logic [63:0]        lookup_entry;

  assign cur_id   = current_task;
  assign cur_time = time_left[cur_id];
  assign cur_due  = cur_time == 8'd0;

  // Lowest unused slot: priority encoder, last match in the downward scan wins.
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = rrts_pkg::TASKS - 1; i >= 0; i--) begin
      if (slot_state[i] == rrts_pkg::SLOT_UNUSED) begin
        free_found = 1'b1;
        free_id    = rrts_pkg::task_id_t'(i);
      end
    end
  end

  // Pointers wrap naturally at the pool size; one place stays empty.
  assign ring_full  = ring_head == rrts_pkg::task_id_t'(ring_tail + 1'b1);
  assign ring_empty = ring_head == ring_tail;

  assign do_create = take && s1_func == rrts_pkg::FUNC_CREATE && free_found;
  assign do_sched  = take && (s1_func == rrts_pkg::FUNC_SCHEDULE ||
                              (s1_func == rrts_pkg::FUNC_RESCHED && cur_due));
  assign do_tick   = take && s1_func == rrts_pkg::FUNC_TICK;

  assign prev_active = cur_id != '0;
  assign push_id     = do_create ? free_id : cur_id;
  assign push_en     = (do_create || (do_sched && prev_active)) && !ring_full;

  // Empty ring plus a re-enqueue: the task just pushed is popped straight back.
  assign pop_en  = do_sched && !(ring_empty && !push_en);
  assign pop_id  = ring_empty ? cur_id : ring_slots[ring_head];
  assign next_id = pop_en ? pop_id : '0;

  assign lookup_id    = do_sched ? next_id : cur_id;
  assign lookup_entry = (lookup_id == '0) ? 64'd0 : entry_table[lookup_id];

  // ---------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrts_pkg::TASKS; i++) begin
        slot_state[i] <= (i == 0) ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_UNUSED;
        time_left[i]  <= 8'd0;
      end
      ring_head     <= '0;
      ring_tail     <= '0;
      current_task  <= '0;
      epoch_length  <= rrts_pkg::EPOCH_RESET;
    end else begin
      if (cfg_write) begin
        epoch_length <= pwdata[7:0];
      end
      if (do_create) begin
        slot_state[free_id] <= rrts_pkg::SLOT_RUNNABLE;
        time_left[free_id]  <= epoch_length;
      end
      if (push_en) begin
        ring_tail <= rrts_pkg::task_id_t'(ring_tail + 1'b1);
      end
      if (pop_en) begin
        ring_head <= rrts_pkg::task_id_t'(ring_head + 1'b1);
      end
      if (do_sched) begin
        if (prev_active) begin
          if (cur_due) begin
            time_left[cur_id] <= epoch_length;
          end
          // the same task picked again stays running
          if (cur_id != next_id) begin
            slot_state[cur_id] <= rrts_pkg::SLOT_RUNNABLE;
          end
        end
        slot_state[next_id] <= rrts_pkg::SLOT_RUNNING;
        current_task        <= next_id;
      end
      if (do_tick && !cur_due) begin
        time_left[cur_id] <= cur_time - 8'd1;
      end
    end
  end

  // Payload tables, no reset.
  always_ff @(posedge clk) begin
    if (do_create) begin
      entry_table[free_id] <= s1_entry;
    end
    if (push_en) begin
      ring_slots[ring_tail] <= push_id;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  rrts_pkg::status_t res_status;
  rrts_pkg::task_id_t res_task;
  rrts_pkg::task_id_t res_prev;
  logic [63:0]        res_entry;

  always_comb begin
    if (s1_func == rrts_pkg::FUNC_CREATE) begin
      res_status = free_found ? rrts_pkg::STATUS_CREATED : rrts_pkg::STATUS_POOL_FULL;
      res_task   = free_found ? free_id : '0;
      res_prev   = '0;
      res_entry  = 64'd0;
    end else if (do_sched) begin
      res_status = rrts_pkg::STATUS_SWITCHED;
      res_task   = next_id;
      res_prev   = cur_id;
      res_entry  = lookup_entry;
    end else begin
      res_status = rrts_pkg::STATUS_NO_SWITCH;
      res_task   = cur_id;
      res_prev   = cur_id;
      res_entry  = lookup_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status     <= res_status;
      task_id    <= res_task;
      prev_id    <= res_prev;
      next_entry <= res_entry;
    end
  end

endmodule

@@ design/rrts_checker.sv @@
module rrts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  task_id,
  input logic [3:0]  prev_id,
  input logic [63:0] next_entry
);

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(task_id) &&
      $stable(prev_id) && $stable(next_entry))
    else $error("stalled result changed");

  a_created: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rrts_pkg::STATUS_CREATED |->
      task_id != 4'd0 && prev_id == 4'd0 && next_entry == 64'd0)
    else $error("bad create result");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rrts_pkg::STATUS_POOL_FULL |->
      task_id == 4'd0 && prev_id == 4'd0 && next_entry == 64'd0)
    else $error("bad pool-full result");

  a_no_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rrts_pkg::STATUS_NO_SWITCH |-> task_id == prev_id &&
      (task_id != 4'd0 || next_entry == 64'd0))
    else $error("bad no-switch result");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .task_id    (task_id),
  .prev_id    (prev_id),
  .next_entry (next_entry)
);
